FILE: hw/rtl/tiip_pkg.sv
// shared types, constants and helpers of the text image parser
package tiip_pkg;

  localparam int unsigned HEADER_BYTES         = 4;
  localparam int unsigned SEGMENT_HEADER_BYTES = 8;
  localparam int unsigned DATA_ALIGN           = 8;

  localparam logic [23:0] CAPACITY_RESET = 24'd65536;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_Q     = 8'h71;

  typedef enum logic [2:0] {
    MODE_START       = 3'd0,
    MODE_ADDR_LEAD   = 3'd1,
    MODE_ADDR_DIGITS = 3'd2,
    MODE_QUIT        = 3'd3,
    MODE_DATA        = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    KIND_SEGMENT    = 3'd0,
    KIND_DATA       = 3'd1,
    KIND_END_Q      = 3'd2,
    KIND_END_NOQ    = 3'd3,
    KIND_TOO_BIG    = 3'd4,
    KIND_NO_SEGMENT = 3'd5
  } kind_e;

  typedef struct packed {
    mode_e       line_mode;
    logic [31:0] addr;
    logic        stopped;
    logic        tok_active;
    logic [7:0]  tok_val;
    logic        seg_open;
    logic [23:0] seg_size;
    logic [23:0] seg_pos;
    logic [23:0] seg_count;
    logic        finished;
  } state_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] value;
    logic [23:0] byte_offset;
    logic [23:0] seg_num;
  } res_t;

  localparam state_t ST_RESET = '{
    line_mode:  MODE_START,
    addr:       32'd0,
    stopped:    1'b0,
    tok_active: 1'b0,
    tok_val:    8'd0,
    seg_open:   1'b0,
    seg_size:   24'd0,
    seg_pos:    24'(HEADER_BYTES),
    seg_count:  24'd0,
    finished:   1'b0
  };

  // {ok, digit}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/tiip_char_if.sv
// character request channel
interface tiip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

FILE: hw/rtl/tiip_res_if.sv
// result request channel
interface tiip_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [23:0] byte_offset;
  logic [23:0] segment_number;

  modport source (output valid, output kind, output value, output byte_offset,
                  output segment_number, input ready);
  modport sink (input valid, input kind, input value, input byte_offset,
                input segment_number, output ready);
endinterface

FILE: hw/rtl/tiip_step.sv
// next-state and result logic for one character
module tiip_step (
  input  tiip_pkg::state_t st_i,
  input  logic [7:0]       chr_i,
  input  logic [23:0]      capacity_i,
  output tiip_pkg::state_t st_o,
  output tiip_pkg::res_t   res_o
);

  typedef struct packed {
    tiip_pkg::state_t st;
    tiip_pkg::res_t   res;
  } step_t;

  function automatic step_t tok_end(input tiip_pkg::state_t s, input logic [23:0] cap);
    step_t       r;
    logic [25:0] at;
    r.st  = s;
    r.res = '0;
    r.st.tok_active = 1'b0;
    at = {2'b0, s.seg_pos} + 26'(tiip_pkg::SEGMENT_HEADER_BYTES) + {2'b0, s.seg_size};
    r.res.valid = 1'b1;
    if (!s.seg_open) begin
      r.st.finished = 1'b1;
      r.res.kind    = tiip_pkg::KIND_NO_SEGMENT;
    end else if (at >= {2'b0, cap}) begin
      r.st.finished = 1'b1;
      r.res.kind    = tiip_pkg::KIND_TOO_BIG;
    end else begin
      r.res.kind        = tiip_pkg::KIND_DATA;
      r.res.value       = {24'd0, s.tok_val};
      r.res.byte_offset = s.seg_size;
      r.st.seg_size     = s.seg_size + 24'd1;
    end
    return r;
  endfunction

  function automatic step_t end_line(input tiip_pkg::state_t s, input logic [23:0] cap);
    step_t       r;
    logic [24:0] padded;
    logic [25:0] pos;
    r.st  = s;
    r.res = '0;
    // data size rounded up to the alignment
    padded = ({1'b0, s.seg_size} + 25'(tiip_pkg::DATA_ALIGN - 1))
           & ~25'(tiip_pkg::DATA_ALIGN - 1);
    pos = {2'b0, s.seg_pos}
        + (s.seg_open ? (26'(tiip_pkg::SEGMENT_HEADER_BYTES) + {1'b0, padded}) : 26'd0);
    case (s.line_mode) inside
      tiip_pkg::MODE_ADDR_LEAD, tiip_pkg::MODE_ADDR_DIGITS: begin
        r.res.valid = 1'b1;
        if (pos >= {2'b0, cap}) begin
          r.st.finished = 1'b1;
          r.res.kind    = tiip_pkg::KIND_TOO_BIG;
        end else begin
          r.st.seg_pos   = pos[23:0];
          r.st.seg_open  = 1'b1;
          r.st.seg_size  = 24'd0;
          r.st.seg_count = s.seg_count + 24'd1;
          r.res.kind     = tiip_pkg::KIND_SEGMENT;
          r.res.value    = s.addr;
        end
      end
      tiip_pkg::MODE_QUIT: begin
        r.st.finished = 1'b1;
        r.res.valid   = 1'b1;
        r.res.kind    = tiip_pkg::KIND_END_Q;
        r.res.value   = {8'd0, s.seg_count};
      end
      tiip_pkg::MODE_DATA: begin
        if (s.tok_active) begin
          r = tok_end(s, cap);
        end
      end
      default: begin
      end
    endcase
    r.st.line_mode  = tiip_pkg::MODE_START;
    r.st.tok_active = 1'b0;
    return r;
  endfunction

  step_t            w;
  logic [4:0]       hex;
  logic             is_ws;
  logic             is_eol;
  tiip_pkg::mode_e  mode;
  logic             stopped;
  logic [7:0]       tok_val;

  assign hex    = tiip_pkg::hex_decode(chr_i);
  assign is_ws  = (chr_i == tiip_pkg::CHAR_SPACE) || (chr_i == tiip_pkg::CHAR_TAB);
  assign is_eol = (chr_i == tiip_pkg::CHAR_CR) || (chr_i == tiip_pkg::CHAR_LF);

  always_comb begin
    w.st    = st_i;
    w.res   = '0;
    mode    = st_i.line_mode;
    stopped = st_i.stopped;
    tok_val = st_i.tok_val;
    if (chr_i == tiip_pkg::CHAR_NUL) begin
      if (!st_i.finished) begin
        w = end_line(st_i, capacity_i);
        if (!w.res.valid) begin
          w.res.valid = 1'b1;
          w.res.kind  = tiip_pkg::KIND_END_NOQ;
          w.res.value = {8'd0, w.st.seg_count};
        end
      end
    end else if (st_i.finished) begin
      w.st = st_i;
    end else if (is_eol) begin
      w = end_line(st_i, capacity_i);
    end else if (st_i.line_mode == tiip_pkg::MODE_START && chr_i == tiip_pkg::CHAR_AT) begin
      w.st.line_mode = tiip_pkg::MODE_ADDR_LEAD;
      w.st.addr      = 32'd0;
      w.st.stopped   = 1'b0;
    end else if (st_i.line_mode == tiip_pkg::MODE_START && chr_i == tiip_pkg::CHAR_Q) begin
      w.st.line_mode = tiip_pkg::MODE_QUIT;
    end else begin
      if (mode == tiip_pkg::MODE_START) begin
        mode = tiip_pkg::MODE_DATA;
      end
      w.st.line_mode = mode;
      case (mode)
        tiip_pkg::MODE_ADDR_LEAD: begin
          if (!is_ws) begin
            w.st.line_mode = tiip_pkg::MODE_ADDR_DIGITS;
            if (hex[4]) begin
              w.st.addr = {28'd0, hex[3:0]};
            end else begin
              w.st.stopped = 1'b1;
            end
          end
        end
        tiip_pkg::MODE_ADDR_DIGITS: begin
          if (!st_i.stopped && hex[4]) begin
            w.st.addr = {st_i.addr[27:0], hex[3:0]};
          end else begin
            w.st.stopped = 1'b1;
          end
        end
        tiip_pkg::MODE_DATA: begin
          if (is_ws) begin
            if (st_i.tok_active) begin
              w = tok_end(w.st, capacity_i);
            end
          end else begin
            if (!st_i.tok_active) begin
              stopped = 1'b0;
              tok_val = 8'd0;
            end
            w.st.tok_active = 1'b1;
            if (!stopped && hex[4]) begin
              w.st.tok_val = {tok_val[3:0], hex[3:0]};
              w.st.stopped = stopped;
            end else begin
              w.st.tok_val = tok_val;
              w.st.stopped = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_o         = w.res;
    res_o.seg_num = (w.st.seg_count != 24'd0) ? (w.st.seg_count - 24'd1) : 24'd0;
    st_o          = (chr_i == tiip_pkg::CHAR_NUL) ? tiip_pkg::ST_RESET : w.st;
  end

endmodule

FILE: hw/rtl/ti_txt_image_parser_core.sv
// top level of the text image parser: input register, step logic, result register
// a character moves from the input register via the step logic into the result register
// one character per cycle when not stalled, set by the single input and result registers
// a stalled result holds its register while the next character waits in the input register
// reset clears the parser state and the pipeline and sets the capacity to 65536 bytes
module ti_txt_image_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [23:0]   cfg_data_i,
  tiip_char_if.sink     chr_i,
  tiip_res_if.source    res_o
);

  logic [23:0]      capacity_q;
  logic             in_vld_q;
  logic [7:0]       in_chr_q;
  tiip_pkg::state_t state_q;
  tiip_pkg::state_t state_d;
  tiip_pkg::res_t   res;
  logic             out_vld_q;
  logic [2:0]       out_kind_q;
  logic [31:0]      out_value_q;
  logic [23:0]      out_offset_q;
  logic [23:0]      out_seg_q;
  logic             advance;

  assign advance     = in_vld_q && (!out_vld_q || res_o.ready);
  assign chr_i.ready = !in_vld_q || advance;

  tiip_step u_step (
    .st_i       (state_q),
    .chr_i      (in_chr_q),
    .capacity_i (capacity_q),
    .st_o       (state_d),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= tiip_pkg::CAPACITY_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      state_q   <= tiip_pkg::ST_RESET;
      out_vld_q <= 1'b0;
    end else begin
      if (chr_i.ready) begin
        in_vld_q <= chr_i.valid;
      end
      if (advance) begin
        state_q   <= state_d;
        out_vld_q <= res.valid;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (chr_i.ready && chr_i.valid) begin
      in_chr_q <= chr_i.character;
    end
    if (advance && res.valid) begin
      out_kind_q   <= res.kind;
      out_value_q  <= res.value;
      out_offset_q <= res.byte_offset;
      out_seg_q    <= res.seg_num;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.kind           = out_kind_q;
  assign res_o.value          = out_value_q;
  assign res_o.byte_offset    = out_offset_q;
  assign res_o.segment_number = out_seg_q;

`ifndef SYNTHESIS
  a_finished_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.finished && in_chr_q != tiip_pkg::CHAR_NUL |-> !res.valid)
    else $error("result produced after the file finished");

  a_nul_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_chr_q == tiip_pkg::CHAR_NUL |=> state_q == tiip_pkg::ST_RESET)
    else $error("end of text did not rearm the parser");

  a_nul_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_chr_q == tiip_pkg::CHAR_NUL && !state_q.finished |=> out_vld_q)
    else $error("end of text gave no result");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chr_i.ready |-> in_vld_q && out_vld_q && !res_o.ready)
    else $error("input stalled without a held result");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res.valid |=> out_vld_q)
    else $error("result lost between step logic and output register");
`endif

endmodule
